FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define SCUB_ASSERT(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`define SCUB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define SCUB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SCUB_ASSERT(label, clk, rst_n, cond, msg)
`define SCUB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define SCUB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: sv/scub_pkg.sv
// ----------------------------------------------------------------------------
// scub_pkg
// types and constants shared by the command bridge modules
// ----------------------------------------------------------------------------
package scub_pkg;

    // item sources
    localparam logic [1:0] CMD_LINK    = 2'd0;
    localparam logic [1:0] CMD_FAR_IN  = 2'd1;
    localparam logic [1:0] CMD_FAR_OUT = 2'd2;

    // link command nibbles
    localparam logic [3:0] LC_RX_POP  = 4'hA;
    localparam logic [3:0] LC_TX_PUSH = 4'hB;
    localparam logic [3:0] LC_TX_ROOM = 4'hC;
    localparam logic [3:0] LC_RX_HAS  = 4'hD;
    localparam logic [3:0] LC_IDENT   = 4'h9;

    // reply words
    localparam logic [15:0] REPLY_IDENT = 16'h0470;
    localparam logic [15:0] REPLY_FLAG  = 16'h0400;
    localparam logic [15:0] REPLY_DATA  = 16'h0800;
    localparam logic [15:0] REPLY_NONE  = 16'h0000;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_NONE,
        OP_IDENT,
        OP_TX_ROOM,
        OP_RX_HAS,
        OP_TX_PUSH,
        OP_RX_POP,
        OP_FAR_PUSH,
        OP_FAR_POP
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } entry_t;

endpackage

FILE: sv/scub_front.sv
// ----------------------------------------------------------------------------
// scub_front
// accepts items and classifies them into back-end operations
// ----------------------------------------------------------------------------
module scub_front
    import scub_pkg::*;
(
    input  logic        start,
    input  logic [1:0]  cmd,
    input  logic [15:0] link_word,
    input  logic [7:0]  far_byte,
    input  logic        q_full,
    output logic        busy,
    output logic        q_push,
    output entry_t      q_entry
);

    assign busy   = q_full;
    assign q_push = start && !q_full;

    always_comb
    begin
        q_entry.op   = OP_NONE;
        q_entry.data = far_byte;
        case (cmd)
            CMD_LINK:
            begin
                q_entry.data = link_word[11:4];
                case (link_word[15:12])
                    LC_IDENT:   q_entry.op = OP_IDENT;
                    LC_TX_ROOM: q_entry.op = OP_TX_ROOM;
                    LC_RX_HAS:  q_entry.op = OP_RX_HAS;
                    LC_TX_PUSH: q_entry.op = OP_TX_PUSH;
                    LC_RX_POP:  q_entry.op = OP_RX_POP;
                    default:    q_entry.op = OP_NONE;
                endcase
            end
            CMD_FAR_IN:  q_entry.op = OP_FAR_PUSH;
            CMD_FAR_OUT: q_entry.op = OP_FAR_POP;
            default:     q_entry.op = OP_NONE;
        endcase
    end

endmodule

FILE: sv/scub_queue.sv
// ----------------------------------------------------------------------------
// scub_queue
// short item queue between the front and back parts
// ----------------------------------------------------------------------------
module scub_queue
    import scub_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output logic   full,
    output logic   not_empty,
    output entry_t head_entry
);

    entry_t                q_mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0]   count_reg, count_next;
    logic                  do_push, do_pop;

    assign full       = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign not_empty  = (count_reg != '0);
    assign head_entry = q_mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: sv/scub_back.sv
// ----------------------------------------------------------------------------
// scub_back
// carries out queued operations on the transmit and receive fifos
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scub_back
    import scub_pkg::*;
#(
    parameter int TX_DEPTH = 64,
    parameter int RX_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        exec,
    input  entry_t      entry,
    output logic        done,
    output logic [15:0] reply_word,
    output logic [7:0]  far_out_byte,
    output logic        far_out_valid,
    output logic        far_accepted
);

    localparam int TX_AW = $clog2(TX_DEPTH);
    localparam int TX_CW = $clog2(TX_DEPTH + 1);
    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int RX_CW = $clog2(RX_DEPTH + 1);

    logic [7:0]       tx_mem [TX_DEPTH];
    logic [7:0]       rx_mem [RX_DEPTH];

    logic [TX_AW-1:0] tx_head_reg, tx_head_next;
    logic [TX_AW-1:0] tx_tail_reg, tx_tail_next;
    logic [TX_CW-1:0] tx_count_reg, tx_count_next;
    logic [RX_AW-1:0] rx_head_reg, rx_head_next;
    logic [RX_AW-1:0] rx_tail_reg, rx_tail_next;
    logic [RX_CW-1:0] rx_count_reg, rx_count_next;

    logic             done_reg;
    logic [15:0]      reply_reg, reply_next;
    logic             tx_sel_reg, rx_sel_reg;
    logic             acc_reg, acc_next;
    logic [7:0]       tx_rd_reg, rx_rd_reg;

    logic             tx_full, tx_empty, rx_full, rx_empty;
    logic             tx_wr, tx_rd, rx_wr, rx_rd;

    assign tx_full  = (tx_count_reg == TX_CW'(TX_DEPTH));
    assign tx_empty = (tx_count_reg == '0);
    assign rx_full  = (rx_count_reg == RX_CW'(RX_DEPTH));
    assign rx_empty = (rx_count_reg == '0);

    // operation decode
    always_comb
    begin
        reply_next = REPLY_NONE;
        acc_next   = 1'b0;
        tx_wr      = 1'b0;
        tx_rd      = 1'b0;
        rx_wr      = 1'b0;
        rx_rd      = 1'b0;
        if (exec)
        begin
            case (entry.op)
                OP_IDENT:    reply_next = REPLY_IDENT;
                OP_TX_ROOM:  reply_next = tx_full ? REPLY_NONE : REPLY_FLAG;
                OP_RX_HAS:   reply_next = rx_empty ? REPLY_NONE : REPLY_FLAG;
                OP_TX_PUSH:
                begin
                    tx_wr      = !tx_full;
                    reply_next = tx_full ? REPLY_NONE : REPLY_FLAG;
                end
                OP_RX_POP:
                begin
                    rx_rd      = !rx_empty;
                    reply_next = rx_empty ? REPLY_NONE : REPLY_DATA;
                end
                OP_FAR_PUSH:
                begin
                    rx_wr    = !rx_full;
                    acc_next = !rx_full;
                end
                OP_FAR_POP:  tx_rd = !tx_empty;
                default:     reply_next = REPLY_NONE;
            endcase
        end
    end

    // pointer and count update
    always_comb
    begin
        tx_head_next  = tx_head_reg;
        tx_tail_next  = tx_tail_reg;
        tx_count_next = tx_count_reg;
        rx_head_next  = rx_head_reg;
        rx_tail_next  = rx_tail_reg;
        rx_count_next = rx_count_reg;
        if (tx_wr)
        begin
            tx_tail_next  = (tx_tail_reg == TX_AW'(TX_DEPTH - 1)) ? '0
                          : tx_tail_reg + 1'b1;
            tx_count_next = tx_count_reg + 1'b1;
        end
        else if (tx_rd)
        begin
            tx_head_next  = (tx_head_reg == TX_AW'(TX_DEPTH - 1)) ? '0
                          : tx_head_reg + 1'b1;
            tx_count_next = tx_count_reg - 1'b1;
        end
        if (rx_wr)
        begin
            rx_tail_next  = (rx_tail_reg == RX_AW'(RX_DEPTH - 1)) ? '0
                          : rx_tail_reg + 1'b1;
            rx_count_next = rx_count_reg + 1'b1;
        end
        else if (rx_rd)
        begin
            rx_head_next  = (rx_head_reg == RX_AW'(RX_DEPTH - 1)) ? '0
                          : rx_head_reg + 1'b1;
            rx_count_next = rx_count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_head_reg  <= '0;
            tx_tail_reg  <= '0;
            tx_count_reg <= '0;
            rx_head_reg  <= '0;
            rx_tail_reg  <= '0;
            rx_count_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            tx_head_reg  <= tx_head_next;
            tx_tail_reg  <= tx_tail_next;
            tx_count_reg <= tx_count_next;
            rx_head_reg  <= rx_head_next;
            rx_tail_reg  <= rx_tail_next;
            rx_count_reg <= rx_count_next;
            done_reg     <= exec;
        end
    end

    // result stage
    always_ff @(posedge clk)
    begin
        reply_reg  <= reply_next;
        acc_reg    <= acc_next;
        tx_sel_reg <= tx_rd;
        rx_sel_reg <= rx_rd;
    end

    // fifo storage
    always_ff @(posedge clk)
    begin
        if (tx_wr)
        begin
            tx_mem[tx_tail_reg] <= entry.data;
        end
        if (tx_rd)
        begin
            tx_rd_reg <= tx_mem[tx_head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_wr)
        begin
            rx_mem[rx_tail_reg] <= entry.data;
        end
        if (rx_rd)
        begin
            rx_rd_reg <= rx_mem[rx_head_reg];
        end
    end

    assign done          = done_reg;
    assign reply_word    = reply_reg | {8'h00, (rx_sel_reg ? rx_rd_reg : 8'h00)};
    assign far_out_byte  = tx_sel_reg ? tx_rd_reg : 8'h00;
    assign far_out_valid = tx_sel_reg;
    assign far_accepted  = acc_reg;

    `SCUB_ASSERT(a_tx_count_bound, clk, rst_n, tx_count_reg <= TX_CW'(TX_DEPTH), "tx count overrun")
    `SCUB_ASSERT(a_rx_count_bound, clk, rst_n, rx_count_reg <= RX_CW'(RX_DEPTH), "rx count overrun")
    `SCUB_ASSERT_NEXT(a_exec_done, clk, rst_n, exec, done, "executed item gave no result")
    `SCUB_ASSERT_IMPL(a_one_kind, clk, rst_n, done, !(far_out_valid && far_accepted), "two result kinds")
    `SCUB_ASSERT_NEXT(a_tx_pop_count, clk, rst_n, tx_rd, tx_count_reg == $past(tx_count_reg) - 1'b1, "tx pop count")

endmodule

FILE: sv/spi_command_uart_bridge_core.sv
// ----------------------------------------------------------------------------
// spi_command_uart_bridge_core
// command word bridge between a link side and a far side through two fifos
// ----------------------------------------------------------------------------
// usage
//   input items: cmd, link_word, far_byte, taken at an edge where start is
//   high and busy is low. cmd 0 carries a link command word, cmd 1 a byte
//   from the far side into the receive fifo, cmd 2 a request from the far
//   side for a byte out of the transmit fifo.
//   results: one per item, in order, on reply_word, far_out_byte,
//   far_out_valid and far_accepted while done is high for one cycle; fields
//   that do not apply to the item are zero.
//   an item taken is written into the item queue, executed by the back end
//   from the queue head, and its result is registered in the result stage.
//   throughput: one item per cycle; the back end executes one queued item
//   per cycle, with a single-ported read and write on each fifo memory.
//   the two-entry item queue never holds more than one item since the back
//   end drains one every cycle, so busy stays low in operation.
//   reset: both fifos empty and the queue empty; fifo storage keeps no
//   reset value, only pointers and counts are cleared.
//   the receiver cannot stall; each result shows for exactly one cycle.
// ----------------------------------------------------------------------------
module spi_command_uart_bridge_core
    import scub_pkg::*;
#(
    parameter int TX_DEPTH = 64,
    parameter int RX_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [15:0] link_word,
    input  logic [7:0]  far_byte,
    output logic        done,
    output logic [15:0] reply_word,
    output logic [7:0]  far_out_byte,
    output logic        far_out_valid,
    output logic        far_accepted
);

    logic   q_full;
    logic   q_push;
    logic   q_not_empty;
    entry_t q_in_entry;
    entry_t q_head_entry;

    scub_front u_front
    (
        .start     (start),
        .cmd       (cmd),
        .link_word (link_word),
        .far_byte  (far_byte),
        .q_full    (q_full),
        .busy      (busy),
        .q_push    (q_push),
        .q_entry   (q_in_entry)
    );

    scub_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in_entry),
        .pop        (q_not_empty),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .head_entry (q_head_entry)
    );

    scub_back #(
        .TX_DEPTH (TX_DEPTH),
        .RX_DEPTH (RX_DEPTH)
    ) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .exec          (q_not_empty),
        .entry         (q_head_entry),
        .done          (done),
        .reply_word    (reply_word),
        .far_out_byte  (far_out_byte),
        .far_out_valid (far_out_valid),
        .far_accepted  (far_accepted)
    );

endmodule
